/* src/framed_xor_packet_receiver_top_assert.svh */
// Assertion macros for the framed XOR packet receiver.
// The clock and reset names are taken from the scope where a macro is used.
`ifndef FRAMED_XOR_PACKET_RECEIVER_TOP_ASSERT_SVH
`define FRAMED_XOR_PACKET_RECEIVER_TOP_ASSERT_SVH

// Check a property on every rising clock edge outside of reset.
`define FXPR_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that an expression holds whenever a result item is offered.
`define FXPR_ASSERT_VALID(lbl, vld, expr, msg) \
	`FXPR_ASSERT_CLK(lbl, (vld) |-> (expr), msg)

`endif

/* src/fxpr_pkg.sv */
// ----------------------------------------------------------------------------
// fxpr_pkg
// Shared constants and types of the framed XOR packet receiver: framing
// bytes, status codes and the result item structure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fxpr_pkg;

	// Framing bytes
	localparam logic [7:0] START_BYTE   = 8'h02;
	localparam logic [7:0] END_BYTE     = 8'h03;
	// Largest length the link can carry; reset value of the length limit
	localparam logic [7:0] LENGTH_LIMIT = 8'd255;

	typedef logic [2:0] status_t;

	// Status codes of a result item
	localparam status_t ST_NONE    = 3'd0;
	localparam status_t ST_PAYLOAD = 3'd1;
	localparam status_t ST_ACCEPT  = 3'd2;
	localparam status_t ST_BADCHK  = 3'd3;
	localparam status_t ST_BADLEN  = 3'd4;
	localparam status_t ST_BADEND  = 3'd5;

	typedef struct packed {
		status_t    status;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic       ack_out;
	} result_t;

endpackage

`default_nettype wire

/* src/fxpr_ifs.sv */
// ----------------------------------------------------------------------------
// fxpr_ifs
// Valid/ready channel interfaces: received bytes in, parse results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fxpr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fxpr_result_if;
	import fxpr_pkg::*;

	logic       valid;
	logic       ready;
	status_t    status;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic       ack_out;

	modport source (output valid, output status, output payload_byte,
		output payload_index, output ack_out, input ready);
	modport sink   (input valid, input status, input payload_byte,
		input payload_index, input ack_out, output ready);
endinterface

`default_nettype wire

/* src/fxpr_in_stage.sv */
// ----------------------------------------------------------------------------
// fxpr_in_stage
// Input register: captures one received byte per item and holds it until
// the parser moves it on into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fxpr_in_stage (
	input  wire logic    clk,
	input  wire logic    arst_n,
	fxpr_byte_if.sink    rx_in,
	input  wire logic    take,
	output logic         valid_s1,
	output logic [7:0]   byte_s1
);

	// Room when empty or when the held byte leaves this cycle
	assign rx_in.ready = !valid_s1 || take;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_in.ready) begin
			valid_s1 <= rx_in.valid;
		end
	end

	// Capture the byte
	always_ff @(posedge clk) begin
		if (rx_in.valid && rx_in.ready) begin
			byte_s1 <= rx_in.rx_byte;
		end
	end

endmodule

`default_nettype wire

/* src/fxpr_parser.sv */
// ----------------------------------------------------------------------------
// fxpr_parser
// Frame state machine: hunt for the start byte, check the length, pass out
// payload bytes with their index, compare the XOR checksum, check the end
// byte. Holds the length limit register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fxpr_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        step,
	input  wire logic [7:0]  rx_byte,
	output fxpr_pkg::result_t res
);
	import fxpr_pkg::*;

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_LEN  = 3'd1;
	localparam logic [2:0] PH_DATA = 3'd2;
	localparam logic [2:0] PH_CHK  = 3'd3;
	localparam logic [2:0] PH_END  = 3'd4;

	logic [2:0] phase_q,     phase_d;
	logic [7:0] frame_len_q, frame_len_d;
	logic [7:0] byte_idx_q,  byte_idx_d;
	logic [7:0] run_xor_q,   run_xor_d;
	logic [7:0] max_len_q;
	logic [7:0] idx_inc;

	assign idx_inc = byte_idx_q + 8'd1;

	// Next state and result for the byte in the input register
	always_comb begin
		phase_d     = phase_q;
		frame_len_d = frame_len_q;
		byte_idx_d  = byte_idx_q;
		run_xor_d   = run_xor_q;
		res         = '0;
		case (phase_q)
			PH_LEN: begin
				if (rx_byte > max_len_q) begin
					res.status = ST_BADLEN;
					phase_d    = PH_HUNT;
				end else begin
					frame_len_d = rx_byte;
					byte_idx_d  = '0;
					run_xor_d   = '0;
					phase_d     = (rx_byte == 8'd0) ? PH_CHK : PH_DATA;
				end
			end
			PH_DATA: begin
				res.status        = ST_PAYLOAD;
				res.payload_byte  = rx_byte;
				res.payload_index = byte_idx_q;
				run_xor_d         = run_xor_q ^ rx_byte;
				byte_idx_d        = idx_inc;
				if (idx_inc == frame_len_q) begin
					phase_d = PH_CHK;
				end
			end
			PH_CHK: begin
				if (rx_byte == run_xor_q) begin
					phase_d = PH_END;
				end else begin
					res.status = ST_BADCHK;
					phase_d    = PH_HUNT;
				end
			end
			PH_END: begin
				if (rx_byte == END_BYTE) begin
					res.status  = ST_ACCEPT;
					res.ack_out = 1'b1;
				end else begin
					res.status = ST_BADEND;
				end
				phase_d = PH_HUNT;
			end
			default: begin
				// Hunting; unused codes fall back here too
				phase_d = PH_HUNT;
				if (rx_byte == START_BYTE) begin
					phase_d    = PH_LEN;
					byte_idx_d = '0;
					run_xor_d  = '0;
				end
			end
		endcase
	end

	// Advance the frame state once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			frame_len_q <= '0;
			byte_idx_q  <= '0;
			run_xor_q   <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			frame_len_q <= frame_len_d;
			byte_idx_q  <= byte_idx_d;
			run_xor_q   <= run_xor_d;
		end
	end

	// Length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= LENGTH_LIMIT;
		end else if (cfg_we) begin
			max_len_q <= cfg_wdata;
		end
	end

endmodule

`default_nettype wire

/* src/fxpr_out_stage.sv */
// ----------------------------------------------------------------------------
// fxpr_out_stage
// Result register: loads the parser's result when the input register holds
// an item and the register is free or being emptied; holds it while stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fxpr_out_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               valid_s1,
	input  wire fxpr_pkg::result_t  res,
	output logic                    take,
	fxpr_result_if.source           res_out
);
	import fxpr_pkg::*;

	logic    valid_s2;
	result_t res_s2;

	// Load when there is an item and the slot frees up
	assign take = valid_s1 && (!valid_s2 || res_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || res_out.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// Hold the result while stalled
	always_ff @(posedge clk) begin
		if (take) begin
			res_s2 <= res;
		end
	end

	assign res_out.valid         = valid_s2;
	assign res_out.status        = res_s2.status;
	assign res_out.payload_byte  = res_s2.payload_byte;
	assign res_out.payload_index = res_s2.payload_index;
	assign res_out.ack_out       = res_s2.ack_out;

endmodule

`default_nettype wire

/* src/framed_xor_packet_receiver_top.sv */
// ----------------------------------------------------------------------------
// framed_xor_packet_receiver_top
// Parses STX / length / payload / XOR checksum / ETX frames from a byte
// stream and reports one result item per received byte.
//
//   channel   direction  payload
//   rx_in     sink       rx_byte[7:0]
//   res_out   source     status[2:0], payload_byte[7:0],
//                        payload_index[7:0], ack_out
//   cfg       write      cfg_we, cfg_wdata[7:0] (length limit)
//
// One byte is accepted per cycle unless rx_in.ready is low; its result is
// offered after it passes the input register, then the result register.
// The frame state advances once per byte, so throughput is one item
// per clock as long as res_out is taken.
// Reset clears the frame state to hunting and sets the length limit to 255.
// A stalled result holds in the result register while one more byte may
// wait in the input register; rx_in.ready falls only when both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module framed_xor_packet_receiver_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	fxpr_byte_if.sink       rx_in,
	fxpr_result_if.source   res_out,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);
	import fxpr_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       take;
	result_t    res;

	fxpr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_in    (rx_in),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	fxpr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (take),
		.rx_byte   (byte_s1),
		.res       (res)
	);

	fxpr_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.res      (res),
		.take     (take),
		.res_out  (res_out)
	);

endmodule

`default_nettype wire

/* src/fxpr_checker.sv */
// ----------------------------------------------------------------------------
// fxpr_checker
// Port-level checks of the receiver's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "framed_xor_packet_receiver_top_assert.svh"

module fxpr_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [2:0] out_status,
	input  wire logic [7:0] out_payload_byte,
	input  wire logic [7:0] out_payload_index,
	input  wire logic       out_ack
);
	import fxpr_pkg::*;

	// Acknowledge only with an accepted frame
	`FXPR_ASSERT_VALID(a_ack_match, out_valid, (out_ack == (out_status == ST_ACCEPT)), "ack_out does not match frame accepted status")

	// Payload fields are zero unless a payload byte is reported
	`FXPR_ASSERT_VALID(a_payload_zero, out_valid && (out_status != ST_PAYLOAD), (out_payload_byte == 8'd0) && (out_payload_index == 8'd0), "payload fields set without payload status")

	// Only defined status codes leave the block
	`FXPR_ASSERT_VALID(a_status_range, out_valid, (out_status <= ST_BADEND), "undefined status code")

	// A stalled result holds
	`FXPR_ASSERT_CLK(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_payload_byte) && $stable(out_payload_index) && $stable(out_ack), "result changed while stalled")

endmodule

bind framed_xor_packet_receiver_top fxpr_checker u_fxpr_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (res_out.valid),
	.out_ready         (res_out.ready),
	.out_status        (res_out.status),
	.out_payload_byte  (res_out.payload_byte),
	.out_payload_index (res_out.payload_index),
	.out_ack           (res_out.ack_out)
);

`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for the framed XOR packet receiver. Byte items are fed through
// the valid/ready input channel, and every result item is checked against a
// frame parser kept in the testbench. A short directed sequence covers the
// framing corner cases. Random traffic follows, mostly well-formed frames
// with some corrupted frames and line noise, under several length limits
// and with idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import fxpr_pkg::*;

	localparam int IDLE_LIMIT = 600;
	localparam int PHASE_ITEMS = 16;

	typedef enum logic [2:0] {
		HUNT_START,
		WAIT_LENGTH,
		IN_PAYLOAD,
		WAIT_CHECKSUM,
		WAIT_END
	} parse_phase_t;

	// Frame parser of the testbench, with the queue of results it expects
	class frame_scoreboard;
		parse_phase_t phase;
		logic [7:0]   frame_len;
		logic [7:0]   byte_idx;
		logic [7:0]   run_xor;
		logic [7:0]   length_limit;
		result_t      expected_reports[$];
		int           failures;
		int           checked;
		int           acks;

		function new();
			phase = HUNT_START;
			frame_len = '0;
			byte_idx = '0;
			run_xor = '0;
			length_limit = LENGTH_LIMIT;
			failures = 0;
			checked = 0;
			acks = 0;
		endfunction

		function void set_limit(logic [7:0] v);
			length_limit = v;
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		// Advance the parser by one accepted byte and queue its report
		function void note_byte(logic [7:0] b);
			result_t r;
			r = '0;
			r.status = ST_NONE;
			case (phase)
				WAIT_LENGTH: begin
					if (b > length_limit) begin
						r.status = ST_BADLEN;
						phase = HUNT_START;
					end else begin
						frame_len = b;
						byte_idx = '0;
						run_xor = '0;
						phase = (b == 8'd0) ? WAIT_CHECKSUM : IN_PAYLOAD;
					end
				end
				IN_PAYLOAD: begin
					r.status = ST_PAYLOAD;
					r.payload_byte = b;
					r.payload_index = byte_idx;
					run_xor = run_xor ^ b;
					byte_idx = byte_idx + 8'd1;
					if (byte_idx == frame_len)
						phase = WAIT_CHECKSUM;
				end
				WAIT_CHECKSUM: begin
					if (b == run_xor) begin
						phase = WAIT_END;
					end else begin
						r.status = ST_BADCHK;
						phase = HUNT_START;
					end
				end
				WAIT_END: begin
					if (b == END_BYTE) begin
						r.status = ST_ACCEPT;
						r.ack_out = 1'b1;
						acks++;
					end else begin
						r.status = ST_BADEND;
					end
					phase = HUNT_START;
				end
				default: begin
					phase = HUNT_START;
					if (b == START_BYTE) begin
						phase = WAIT_LENGTH;
						byte_idx = '0;
						run_xor = '0;
					end
				end
			endcase
			expected_reports.push_back(r);
		endfunction

		// Compare one accepted result with the oldest expected report
		function void check_result(result_t got);
			result_t exp;
			bit bad;
			bad = 1'b0;
			if (expected_reports.size() == 0) begin
				$error("unexpected result: status %0d byte %0h index %0d ack %0b",
					got.status, got.payload_byte, got.payload_index, got.ack_out);
				failures++;
				return;
			end
			exp = expected_reports.pop_front();
			checked++;
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				bad = 1'b1;
			end
			if (got.payload_byte !== exp.payload_byte) begin
				$error("payload_byte: expected %0h, got %0h",
					exp.payload_byte, got.payload_byte);
				bad = 1'b1;
			end
			if (got.payload_index !== exp.payload_index) begin
				$error("payload_index: expected %0d, got %0d",
					exp.payload_index, got.payload_index);
				bad = 1'b1;
			end
			if (got.ack_out !== exp.ack_out) begin
				$error("ack_out: expected %0b, got %0b", exp.ack_out, got.ack_out);
				bad = 1'b1;
			end
			if (bad)
				failures++;
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	fxpr_byte_if   rx_if ();
	fxpr_result_if res_if ();

	frame_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int bytes_sent;
	int limits_written;
	int idle_cycles;

	framed_xor_packet_receiver_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_in     (rx_if),
		.res_out   (res_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Check each accepted result, then pick ready for the next cycle
	always @(posedge clk) begin
		result_t got;
		if (arst_n && res_if.valid && res_if.ready) begin
			got.status = res_if.status;
			got.payload_byte = res_if.payload_byte;
			got.payload_index = res_if.payload_index;
			got.ack_out = res_if.ack_out;
			sb.check_result(got);
		end
		res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// End the run when neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$error("no item moved for %0d cycles", IDLE_LIMIT);
				$display("tb failed");
				$finish;
			end
		end
	end

	// Offer one byte, idling at random first, and hold it until taken
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	// Send one frame with random payload, optionally breaking its tail
	task automatic send_frame(input logic [7:0] len, input bit bad_chk, input bit bad_end);
		logic [7:0] x;
		logic [7:0] b;
		logic [7:0] tail;
		x = '0;
		send_byte(START_BYTE);
		send_byte(len);
		for (int i = 0; i < int'(len); i++) begin
			b = 8'($urandom);
			x = x ^ b;
			send_byte(b);
		end
		if (bad_chk) begin
			send_byte(x ^ 8'($urandom_range(1, 255)));
			return;
		end
		send_byte(x);
		if (bad_end) begin
			tail = ($urandom_range(0, 1) == 0) ? START_BYTE : 8'($urandom);
			if (tail == END_BYTE)
				tail = START_BYTE;
			send_byte(tail);
		end else begin
			send_byte(END_BYTE);
		end
	endtask

	// Mostly good frames, plus noise, oversize lengths and broken tails
	task automatic send_random_traffic(input int count);
		int goal;
		int r;
		int cap;
		logic [7:0] lim;
		goal = bytes_sent + count;
		while (bytes_sent < goal) begin
			r = $urandom_range(0, 99);
			lim = sb.length_limit;
			if (r < 6) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			end else if (r < 14 && lim != 8'hFF) begin
				send_byte(START_BYTE);
				send_byte(8'($urandom_range(int'(lim) + 1, 255)));
			end else begin
				cap = ($urandom_range(0, 9) == 0) ? 40 : 10;
				if (cap > int'(lim))
					cap = int'(lim);
				send_frame(8'($urandom_range(0, cap)), r >= 14 && r < 24, r >= 24 && r < 32);
			end
		end
	endtask

	// Drop valid and hold until every expected report has come back
	task automatic wait_drained();
		rx_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_limit(v);
		limits_written++;
	endtask

	initial begin
		logic [7:0] seq[$];
		logic [7:0] limits[8];
		arst_n = 1'b0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = '0;
		res_if.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		bytes_sent = 0;
		limits_written = 0;
		idle_cycles = 0;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset limit: garbage while hunting, zero length,
		// start byte as data, bad checksum, bad end with a start byte there
		seq = {8'hFF, 8'h00,
			START_BYTE, 8'h00, 8'h00, END_BYTE,
			START_BYTE, 8'h03, 8'hFF, START_BYTE, 8'h00, 8'hFD, END_BYTE,
			START_BYTE, 8'h01, 8'hAA, 8'h00,
			START_BYTE, 8'h01, 8'h55, 8'h55, START_BYTE};
		foreach (seq[i])
			send_byte(seq[i]);
		wait_drained();

		// Directed, limit 1: length too large, then length at the limit
		write_limit(8'd1);
		seq = {START_BYTE, 8'h02, START_BYTE, 8'h01, 8'h80, 8'h80, END_BYTE};
		foreach (seq[i])
			send_byte(seq[i]);

		// Random phases over several limits and idle patterns
		limits = '{8'd255, 8'd0, 8'd1, 8'($urandom_range(2, 253)),
			8'd254, 8'd255, 8'($urandom_range(2, 253)), 8'd128};
		for (int p = 0; p < 8; p++) begin
			wait_drained();
			write_limit(limits[p]);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 51;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 51;
				end
				default: begin
					send_idle_pct = 38;
					recv_stall_pct = 38;
				end
			endcase
			send_random_traffic(PHASE_ITEMS);
			// one frame of the longest length, to reach the last index
			if (limits[p] == 8'd255 && p == 5)
				send_frame(8'd255, 1'b0, 1'b0);
		end
		wait_drained();

		$display("Sent %0d bytes under %0d length limit settings and four idle patterns.",
			bytes_sent, limits_written);
		$display("Checked %0d results, %0d frames acknowledged, %0d bad results.",
			sb.checked, sb.acks, sb.failures);
		if (sb.failures == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
